@@ rtl/core/cmu8_pkg.sv @@
// ----------------------------------------------------------------------------
// cmu8_pkg
// shared types and constants for the combining mark utf-8 inserter
// ----------------------------------------------------------------------------
package cmu8_pkg;

  localparam int unsigned MaxBytes = 7;
  localparam int unsigned CntW     = 3;

  localparam logic [31:0] MarkReset = 32'd818;

  localparam logic       CmdText   = 1'b0;
  localparam logic       CmdEncode = 1'b1;

  localparam logic [31:0] Lim1 = 32'h0000_007F;
  localparam logic [31:0] Lim2 = 32'h0000_07FF;
  localparam logic [31:0] Lim3 = 32'h0000_FFFF;
  localparam logic [31:0] Lim4 = 32'h001F_FFFF;
  localparam logic [31:0] Lim5 = 32'h03FF_FFFF;
  localparam logic [31:0] Lim6 = 32'h7FFF_FFFF;

  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] Lead5    = 8'hF8;
  localparam logic [7:0] Lead6    = 8'hFC;
  localparam logic [7:0] ContMark = 8'h80;

  localparam logic [23:0] Replacement = 24'hEFBFBD;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  text_byte;
    logic [31:0] code_point;
  } item_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } burst_t;

endpackage

@@ rtl/core/combining_mark_utf8_inserter_unit.sv @@
// an input item is registered in stage a, then its encoded burst is loaded into
//   the output byte register; each item leaves as its byte count (1 to 7) of beats on
//   the single byte-wide output channel; the next item is taken while bytes drain
// reset (rst_n low, synchronous): pipeline emptied, mark code point = U+0332
// ----------------------------------------------------------------------------
// combining_mark_utf8_inserter_unit
// text byte echo with combining mark insertion and utf-8 code point encoder
// ----------------------------------------------------------------------------
module combining_mark_utf8_inserter_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // mark_code_point

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // text_byte [7:0], code_point [39:8]
  input  logic        in_tuser,      // cmd

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // out_byte
  output logic        out_tlast
);

  logic [31:0]      mark_r;
  logic             a_valid_r;
  cmu8_pkg::item_t  a_item_r;
  cmu8_pkg::burst_t burst;

  logic             b_valid_r;
  logic [6:0][7:0]  bytes_r;
  logic [2:0]       cnt_r;
  logic [2:0]       idx_r;
  logic [2:0]       idx_nxt;

  logic in_xfer;
  logic out_xfer;
  logic b_last;
  logic b_done;
  logic load_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= cmu8_pkg::MarkReset;
    end else if (cfg_wr_en) begin
      mark_r <= cfg_wr_data;
    end
  end

  assign b_last   = (idx_r == cnt_r - 3'd1);
  assign out_xfer = out_tvalid && out_tready;
  assign b_done   = out_xfer && b_last;
  assign load_b   = a_valid_r && (!b_valid_r || b_done);
  assign in_tready = !a_valid_r || load_b;
  assign in_xfer  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_item_r.cmd        <= in_tuser;
      a_item_r.text_byte  <= in_tdata[7:0];
      a_item_r.code_point <= in_tdata[39:8];
    end
  end

  cmu8_encoder u_encoder (
    .item            (a_item_r),
    .mark_code_point (mark_r),
    .burst           (burst)
  );

  always_comb begin
    idx_nxt = idx_r;
    priority if (load_b) begin
      idx_nxt = 3'd0;
    end else if (out_xfer) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      idx_r     <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
      priority if (load_b) begin
        b_valid_r <= 1'b1;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      bytes_r <= burst.bytes;
      cnt_r   <= burst.count;
    end
  end

  assign out_tvalid = b_valid_r;
  assign out_tdata  = bytes_r[idx_r];
  assign out_tlast  = b_last;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (idx_r < cnt_r))
    else $error("byte index beyond burst length");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (cnt_r != 3'd0))
    else $error("empty burst held for output");

  a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load_b |=> (b_valid_r && idx_r == 3'd0))
    else $error("new burst not started at first byte");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (b_done && !load_b) |=> !b_valid_r)
    else $error("burst still valid after last byte");

endmodule

@@ rtl/core/cmu8_encoder.sv @@
// ----------------------------------------------------------------------------
// cmu8_encoder
// expands one item into its output bytes: the echoed text byte, plus the mark
// after a letter or digit, or a lone utf-8 encoding of the given code point
// (original 1 to 6 byte form, U+FFFD above 7FFFFFFF)
module cmu8_encoder (
  input  cmu8_pkg::item_t  item,
  input  logic [31:0]      mark_code_point,
  output cmu8_pkg::burst_t burst
);

  typedef struct packed {
    logic [5:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  function automatic logic [7:0] cont(input logic [5:0] g);
    cont = cmu8_pkg::ContMark | {2'b00, g};
  endfunction

  function automatic utf8_t enc(input logic [31:0] c);
    utf8_t r;
    r = '0;
    priority if (c <= cmu8_pkg::Lim1) begin
      r.b[0] = c[7:0];
      r.n    = 3'd1;
    end else if (c <= cmu8_pkg::Lim2) begin
      r.b[0] = cmu8_pkg::Lead2 | {3'b000, c[10:6]};
      r.b[1] = cont(c[5:0]);
      r.n    = 3'd2;
    end else if (c <= cmu8_pkg::Lim3) begin
      r.b[0] = cmu8_pkg::Lead3 | {4'b0000, c[15:12]};
      r.b[1] = cont(c[11:6]);
      r.b[2] = cont(c[5:0]);
      r.n    = 3'd3;
    end else if (c <= cmu8_pkg::Lim4) begin
      r.b[0] = cmu8_pkg::Lead4 | {5'b00000, c[20:18]};
      r.b[1] = cont(c[17:12]);
      r.b[2] = cont(c[11:6]);
      r.b[3] = cont(c[5:0]);
      r.n    = 3'd4;
    end else if (c <= cmu8_pkg::Lim5) begin
      r.b[0] = cmu8_pkg::Lead5 | {6'b000000, c[25:24]};
      r.b[1] = cont(c[23:18]);
      r.b[2] = cont(c[17:12]);
      r.b[3] = cont(c[11:6]);
      r.b[4] = cont(c[5:0]);
      r.n    = 3'd5;
    end else if (c <= cmu8_pkg::Lim6) begin
      r.b[0] = cmu8_pkg::Lead6 | {7'b0000000, c[30]};
      r.b[1] = cont(c[29:24]);
      r.b[2] = cont(c[23:18]);
      r.b[3] = cont(c[17:12]);
      r.b[4] = cont(c[11:6]);
      r.b[5] = cont(c[5:0]);
      r.n    = 3'd6;
    end else begin
      r.b[0] = cmu8_pkg::Replacement[23:16];
      r.b[1] = cmu8_pkg::Replacement[15:8];
      r.b[2] = cmu8_pkg::Replacement[7:0];
      r.n    = 3'd3;
    end
    return r;
  endfunction

  utf8_t mark_enc;
  utf8_t cp_enc;
  logic  is_alnum;

  assign mark_enc = enc(mark_code_point);
  assign cp_enc   = enc(item.code_point);

  assign is_alnum = (item.text_byte >= 8'h30 && item.text_byte <= 8'h39) ||
                    (item.text_byte >= 8'h41 && item.text_byte <= 8'h5A) ||
                    (item.text_byte >= 8'h61 && item.text_byte <= 8'h7A);

  always_comb begin
    burst = '0;
    unique case (item.cmd)
      cmu8_pkg::CmdText: begin
        burst.bytes[0] = item.text_byte;
        burst.count    = 3'd1;
        if (is_alnum) begin
          for (int i = 0; i < 6; i++) begin
            burst.bytes[i+1] = mark_enc.b[i];
          end
          burst.count = mark_enc.n + 3'd1;
        end
      end
      cmu8_pkg::CmdEncode: begin
        for (int i = 0; i < 6; i++) begin
          burst.bytes[i] = cp_enc.b[i];
        end
        burst.count = cp_enc.n;
      end
      default: burst = '0;
    endcase
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the combining mark utf-8 inserter byte by byte against a predictor
// that echoes text bytes, appends the utf-8 form of the mark after letters
// and digits, and encodes code points in the 1 to 6 byte form or U+FFFD, with
// random stalls on both stream sides in most segments and several mark settings
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  class utf8_scoreboard;
    logic [31:0] mark;
    out_beat_t   expected_beats[$];
    logic [7:0]  burst[$];
    int          errors;

    function new();
      mark   = cmu8_pkg::MarkReset;
      errors = 0;
    endfunction

    function void encode(logic [31:0] v);
      int         n;
      logic [7:0] lead;
      logic [31:0] shifted;
      if (v > cmu8_pkg::Lim6) begin
        burst.push_back(cmu8_pkg::Replacement[23:16]);
        burst.push_back(cmu8_pkg::Replacement[15:8]);
        burst.push_back(cmu8_pkg::Replacement[7:0]);
        return;
      end
      if (v <= cmu8_pkg::Lim1) begin
        burst.push_back(v[7:0]);
        return;
      end
      if (v <= cmu8_pkg::Lim2) begin
        n = 2; lead = cmu8_pkg::Lead2;
      end else if (v <= cmu8_pkg::Lim3) begin
        n = 3; lead = cmu8_pkg::Lead3;
      end else if (v <= cmu8_pkg::Lim4) begin
        n = 4; lead = cmu8_pkg::Lead4;
      end else if (v <= cmu8_pkg::Lim5) begin
        n = 5; lead = cmu8_pkg::Lead5;
      end else begin
        n = 6; lead = cmu8_pkg::Lead6;
      end
      shifted = v >> (6 * (n - 1));
      burst.push_back(lead | shifted[7:0]);
      for (int k = n - 2; k >= 0; k--) begin
        shifted = v >> (6 * k);
        burst.push_back(cmu8_pkg::ContMark | {2'b00, shifted[5:0]});
      end
    endfunction

    function void note_item(logic cmd, logic [7:0] text_byte, logic [31:0] code_point);
      out_beat_t beat;
      burst.delete();
      if (cmd == cmu8_pkg::CmdText) begin
        burst.push_back(text_byte);
        if ((text_byte >= 8'h30 && text_byte <= 8'h39) ||
            (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
            (text_byte >= 8'h61 && text_byte <= 8'h7A)) begin
          encode(mark);
        end
      end else begin
        encode(code_point);
      end
      foreach (burst[i]) begin
        beat.out_byte = burst[i];
        beat.out_last = (i == burst.size() - 1);
        expected_beats.push_back(beat);
      end
    endfunction

    function void check_result(logic [7:0] out_byte, logic out_last);
      out_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        $error("unexpected transaction: out_byte %h out_last %b", out_byte, out_last);
        errors++;
        return;
      end
      exp_beat = expected_beats.pop_front();
      if (out_byte !== exp_beat.out_byte) begin
        $error("out_byte: expected %h, actual %h", exp_beat.out_byte, out_byte);
        errors++;
      end
      if (out_last !== exp_beat.out_last) begin
        $error("out_last: expected %b, actual %b", exp_beat.out_last, out_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;     // text_byte [7:0], code_point [39:8]
  logic        in_tuser = 1'b0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // out_byte
  logic        out_tlast;

  int send_idle_pct = 17;
  int recv_idle_pct = 73;

  utf8_scoreboard sb = new();

  combining_mark_utf8_inserter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast);
    end
  end

  task automatic send_item(logic cmd, logic [7:0] text_byte, logic [31:0] code_point);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {code_point, text_byte};
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, text_byte, code_point);
  endtask

  task automatic send_random();
    logic        cmd;
    logic [7:0]  text_byte;
    logic [31:0] code_point;
    cmd        = 1'($urandom_range(1));
    code_point = $urandom >> $urandom_range(31);
    if ($urandom_range(1)) begin
      case ($urandom_range(2))
        0: text_byte = 8'(8'h30 + $urandom_range(9));
        1: text_byte = 8'(8'h41 + $urandom_range(25));
        default: text_byte = 8'(8'h61 + $urandom_range(25));
      endcase
    end else begin
      text_byte = 8'($urandom_range(255));
    end
    send_item(cmd, text_byte, code_point);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mark(logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.mark = value;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0]  text_set[11];
    logic [31:0] point_set[13];
    logic [31:0] mark_set[12];

    text_set  = '{8'h00, 8'h30, 8'h39, 8'h41, 8'h5A, 8'h5B, 8'h61, 8'h7A, 8'h7B,
                  8'h80, 8'hFF};
    point_set = '{32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF, 32'h10000,
                  32'h1FFFFF, 32'h200000, 32'h3FFFFFF, 32'h4000000,
                  32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
    mark_set  = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF, 32'h10000,
                  32'h1FFFFF, 32'h3FFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, $urandom};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under the reset mark
    foreach (text_set[i]) send_item(cmu8_pkg::CmdText, text_set[i], $urandom);
    foreach (point_set[i]) begin
      send_item(cmu8_pkg::CmdEncode, 8'($urandom_range(255)), point_set[i]);
    end

    for (int seg = 0; seg < 12; seg++) begin
      wait_drained();
      case (seg / 4)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_mark(mark_set[seg]);
      repeat (35) send_random();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cmu8_pkg.sv
rtl/core/cmu8_encoder.sv
rtl/core/combining_mark_utf8_inserter_unit.sv
test/testbench.sv
